>>> src/assert_macros.svh
// Assertion macros for the image packetiser.
// Included by the top level only; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every clock edge outside reset.
`define IPK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that cond at one edge implies nxt at the following edge.
`define IPK_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

>>> src/ipk_pkg.sv
// Shared types, constants and header byte function for the image packetiser.
// No dependencies.
package ipk_pkg;

  localparam int unsigned HdrLen   = 21;
  localparam int unsigned HdrBits  = HdrLen * 8;
  localparam logic [10:0] PayloadCap = 11'd1493;

  typedef enum logic [2:0] {
    RegDestMac   = 3'd0,
    RegSrcMac    = 3'd1,
    RegEtherType = 3'd2,
    RegHeight    = 3'd3,
    RegWidth     = 3'd4,
    RegChannels  = 3'd5,
    RegPayload   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [2:0]  channel_count;
    logic [10:0] payload_max;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    dest_mac:      48'hFFFF_FFFF_FFFF,
    src_mac:       48'h0011_2233_4455,
    ether_type:    16'h1515,
    image_height:  16'd480,
    image_width:   16'd640,
    channel_count: 3'd3,
    payload_max:   11'd1493
  };

  // One accepted pixel and what it means for framing.
  typedef struct packed {
    logic [7:0]  pixel;
    logic        hdr;        // first pixel of a frame: header goes first
    logic        frame_end;
    logic        image_end;
    logic [15:0] seq;
  } item_t;

  // Header byte idx (0 = first on the wire); big-endian fields.
  function automatic logic [7:0] hdr_byte(input cfg_t cfg, input logic [15:0] seq,
                                          input logic [4:0] idx);
    logic [HdrBits-1:0] vec;
    logic [7:0]         pos;
    vec = {cfg.dest_mac, cfg.src_mac, cfg.ether_type, cfg.image_height,
           cfg.image_width, 5'd0, cfg.channel_count, seq};
    pos = 8'(HdrBits - 8) - {idx, 3'b000};
    if (idx < 5'(HdrLen)) begin
      return vec[pos +: 8];
    end
    return 8'd0;
  endfunction

endpackage

>>> src/ipk_ctrl.sv
// Image position and frame counters; classifies each incoming pixel word.
// Depends on ipk_pkg.
module ipk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ipk_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  logic [7:0]    pixel_i,
  output ipk_pkg::item_t item_o
);
  import ipk_pkg::*;

  logic [15:0] seq_q, seq_d;
  logic [10:0] pcount_q, pcount_d;
  logic [1:0]  ch_q, ch_d;
  logic [15:0] col_q, col_d, row_q, row_d;

  logic [2:0]  chans;
  logic [10:0] limit, pcount_inc;
  logic [16:0] width1, height1;
  logic        last_ch, last_col, last_row, img_end, frm_end;

  always_comb begin
    if (cfg_i.channel_count == 3'd0)     chans = 3'd1;
    else if (cfg_i.channel_count > 3'd4) chans = 3'd4;
    else                                 chans = cfg_i.channel_count;

    if (cfg_i.payload_max == 11'd0)           limit = 11'd1;
    else if (cfg_i.payload_max > PayloadCap)  limit = PayloadCap;
    else                                      limit = cfg_i.payload_max;

    width1  = (cfg_i.image_width  == 16'd0) ? 17'd1 : {1'b0, cfg_i.image_width};
    height1 = (cfg_i.image_height == 16'd0) ? 17'd1 : {1'b0, cfg_i.image_height};

    // "at or past the last" so a shrunk dimension wraps at once
    last_ch  = ({1'b0, ch_q} + 3'd1) >= chans;
    last_col = ({1'b0, col_q} + 17'd1) >= width1;
    last_row = ({1'b0, row_q} + 17'd1) >= height1;
    img_end  = last_ch && last_col && last_row;
    pcount_inc = pcount_q + 11'd1;
    frm_end  = img_end || (pcount_inc >= limit);

    pcount_d = frm_end ? 11'd0 : pcount_inc;
    seq_d    = img_end ? 16'd0 : (frm_end ? seq_q + 16'd1 : seq_q);
    ch_d     = last_ch ? 2'd0 : ch_q + 2'd1;
    col_d    = col_q;
    row_d    = row_q;
    if (last_ch) begin
      col_d = last_col ? 16'd0 : col_q + 16'd1;
      if (last_col) begin
        row_d = last_row ? 16'd0 : row_q + 16'd1;
      end
    end

    item_o.pixel     = pixel_i;
    item_o.hdr       = (pcount_q == 11'd0);
    item_o.frame_end = frm_end;
    item_o.image_end = img_end;
    item_o.seq       = seq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= '0;
      pcount_q <= '0;
      ch_q     <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else if (accept_i) begin
      seq_q    <= seq_d;
      pcount_q <= pcount_d;
      ch_q     <= ch_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

>>> src/ipk_emit.sv
// Holding stage plus header sequencer and output register.
// Depends on ipk_pkg.
module ipk_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ipk_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  input  ipk_pkg::item_t item_i,
  output logic           in_ready_o,
  output logic           hold_valid_o,
  output logic           hold_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o,
  output logic           frame_end_o,
  output logic           image_end_o
);
  import ipk_pkg::*;

  logic        hold_valid_q, hold_valid_d;
  item_t       hold_q;
  logic [4:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q;
  logic        run_last_q, frame_end_q, image_end_q;

  logic out_free, in_hdr, emit, pop, load;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    in_hdr   = hold_q.hdr && (idx_q < 5'(HdrLen));
    emit     = hold_valid_q && out_free;
    pop      = emit && !in_hdr;
    load     = in_valid_i && (!hold_valid_q || pop);

    hold_valid_d = load ? 1'b1 : (pop ? 1'b0 : hold_valid_q);
    idx_d        = emit ? (in_hdr ? idx_q + 5'd1 : 5'd0) : idx_q;
    out_valid_d  = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hold_q <= item_i;
    end
    if (emit) begin
      byte_q      <= in_hdr ? hdr_byte(cfg_i, hold_q.seq, idx_q) : hold_q.pixel;
      run_last_q  <= !in_hdr;
      frame_end_q <= !in_hdr && hold_q.frame_end;
      image_end_q <= !in_hdr && hold_q.image_end;
    end
  end

  assign in_ready_o   = !hold_valid_q || pop;
  assign hold_valid_o = hold_valid_q;
  assign hold_pop_o   = pop;
  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign run_last_o   = run_last_q;
  assign frame_end_o  = frame_end_q;
  assign image_end_o  = image_end_q;

endmodule

>>> src/image_to_ethernet_packetizer.sv
// Top level of the image packetiser: configuration registers, counters, emitter.
// Depends on ipk_pkg, ipk_ctrl, ipk_emit and assert_macros.svh.
//
// Usage:
// Pixel bytes enter on s_axis (one byte per word, row/column/channel order).
// Raw Ethernet frame bytes leave on m_axis, one byte per word. Each frame is a
// 21-byte header (dest MAC, src MAC, EtherType, height, width, channels,
// sequence number) and then up to payload_max pixel bytes. m_axis_tlast marks
// the final byte of a frame; tuser bit 0 marks the last byte caused by one
// input word, tuser bit 1 the final byte of the image.
// A pixel passes through the holding stage and then the output register on its
// way to m_axis; a frame-opening pixel follows its 21 header bytes.
// One byte leaves per cycle while m_axis_tready is high, set by the single
// output register, so mid-frame pixels flow at one word per cycle; a
// frame-opening pixel holds the input while its header drains.
// A pixel is accepted while an earlier result waits; when m_axis stalls the
// holding stage and output register fill and s_axis_tready drops. Reset clears
// all counters and loads the configuration defaults. Configuration is written
// through cfg_we_i/cfg_index_i/cfg_data_i by the user only while idle (unenforced).
module image_to_ethernet_packetizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // frame_end
  output logic [1:0]  m_axis_tuser    // [0] run_last, [1] image_end
);
  import ipk_pkg::*;

  `include "assert_macros.svh"

  cfg_t  cfg_q;
  item_t item;
  logic  accept, hold_valid, hold_pop, run_last, image_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegDestMac:   cfg_q.dest_mac      <= cfg_data_i;
        RegSrcMac:    cfg_q.src_mac       <= cfg_data_i;
        RegEtherType: cfg_q.ether_type    <= cfg_data_i[15:0];
        RegHeight:    cfg_q.image_height  <= cfg_data_i[15:0];
        RegWidth:     cfg_q.image_width   <= cfg_data_i[15:0];
        RegChannels:  cfg_q.channel_count <= cfg_data_i[2:0];
        RegPayload:   cfg_q.payload_max   <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  ipk_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .pixel_i  (s_axis_tdata),
    .item_o   (item)
  );

  ipk_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .item_i       (item),
    .in_ready_o   (s_axis_tready),
    .hold_valid_o (hold_valid),
    .hold_pop_o   (hold_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .run_last_o   (run_last),
    .frame_end_o  (m_axis_tlast),
    .image_end_o  (image_end)
  );

  assign m_axis_tuser = {image_end, run_last};

  // image end is always a frame end, and a frame end is always a pixel word
  `IPK_ASSERT(a_img_in_frame, !(m_axis_tvalid && image_end) || m_axis_tlast, "image end, no tlast")
  `IPK_ASSERT(a_frame_is_pixel, !(m_axis_tvalid && m_axis_tlast) || run_last, "tlast on header")
  // a held word stays until its pixel byte has gone out
  `IPK_ASSERT_NEXT(a_hold_kept, hold_valid && !hold_pop, hold_valid, "held word lost")

endmodule
